// ----- hdl/les_pkg.sv -----
// Shared types and constants for the Laplacian edge stream block.
package les_pkg;

  localparam int unsigned PIX_W = 8;

  localparam logic [13:0] GRAY_K0 = 14'd4899;
  localparam logic [13:0] GRAY_K1 = 14'd9617;
  localparam logic [13:0] GRAY_K2 = 14'd1868;
  localparam logic [21:0] GRAY_ROUND = 22'd8192;
  localparam int unsigned GRAY_SHIFT = 14;

  localparam int unsigned OUT_DEPTH = 3;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             frame_end;
    logic [PIX_W-1:0] edge_value;
  } out_item_t;

endpackage

// ----- hdl/les_line_ram.sv -----
// Line store memory: one write port, one read port with registered read data.
module les_line_ram
  import les_pkg::*;
#(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/les_out_fifo.sv -----
// Small result queue between the edge stage and the output stream.
module les_out_fifo
  import les_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t item_o,
  output logic [1:0] count_o
);

  out_item_t  items_q [OUT_DEPTH];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign item_o  = items_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == 2'(OUT_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == 2'(OUT_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      items_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- hdl/laplacian_edge_stream.sv -----
// Top level: gray conversion, line store, 3x3 window and Laplacian edge output.
//
// Input stream s_axis_*: one colour pixel per request in raster order,
// tdata = {chan2, chan1, chan0}. Output stream m_axis_*: one edge value per
// interior pixel, tdata = edge_value, tlast marks the last result of a frame.
// The result for centre (y-1,x-1) comes out when pixel (y,x) is taken; the
// first two rows and first two columns of each row give no result.
// A result is registered in stage 1 and then in the result queue before it is valid.
// Throughput: one pixel per cycle while the result queue has room, set by the
// single line store memory, which is read when a pixel is taken and written back
// in the next cycle with {new gray, previous middle row}.
// A three-entry result queue holds results while m_axis_tready is low; the
// input keeps taking pixels until the queue plus the pixel in flight fill it.
// Configuration writes (frame_width, frame_height) restart the frame: the
// position counters and window clear, the line store keeps its contents.
// Reset sets width 640 and height 480 (width limited to MAX_WIDTH) and starts
// at the top left pixel. The line store needs no clearing after reset.
module laplacian_edge_stream
  import les_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // chan0 [7:0], chan1 [15:8], chan2 [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // edge_value [7:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_wdata_i
);

  localparam int unsigned CW      = $clog2(MAX_WIDTH);
  localparam int unsigned CMPW    = (CW + 1 > 12) ? CW + 1 : 12;
  localparam int unsigned W_RESET = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int unsigned RAM_W   = 2 * PIX_W;

  logic [CW-1:0] w_last_q, w_last_d;
  logic [11:0]   h_last_q, h_last_d;
  logic [CW-1:0] x_q, x_d;
  logic [11:0]   y_q, y_d;

  logic          accept;
  logic [21:0]   gray_sum;
  logic [PIX_W-1:0] gray;

  logic          s1_valid_q;
  logic [PIX_W-1:0] s1_gray_q;
  logic [CW-1:0] s1_x_q;
  logic          s1_produce_q;
  logic          s1_frame_end_q;

  logic [PIX_W-1:0] win_left_q, win_up_q, win_ctr_q, win_down_q;

  logic [RAM_W-1:0] ram_rdata;
  logic [PIX_W-1:0] rd_up, rd_mid;
  logic signed [10:0] lap;
  logic [10:0]   lap_abs;
  out_item_t     res_item;
  out_item_t     out_item;
  logic [1:0]    fifo_count;
  logic [CMPW-1:0] fw_ext;
  logic [12:0]   fh;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (3'(fifo_count) + 3'(s1_valid_q)) < 3'(OUT_DEPTH);

  assign gray_sum = 22'(s_axis_tdata[7:0]) * 22'(GRAY_K0)
                  + 22'(s_axis_tdata[15:8]) * 22'(GRAY_K1)
                  + 22'(s_axis_tdata[23:16]) * 22'(GRAY_K2) + GRAY_ROUND;
  assign gray = gray_sum[GRAY_SHIFT +: PIX_W];

  // register clamping
  assign fw_ext = CMPW'(cfg_wdata_i[11:0]);
  assign fh     = cfg_wdata_i;

  always_comb begin
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          if (fw_ext < CMPW'(3)) begin
            w_last_d = CW'(2);
          end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
            w_last_d = CW'(MAX_WIDTH - 1);
          end else begin
            w_last_d = CW'(fw_ext - CMPW'(1));
          end
        end
        REG_FRAME_HEIGHT: begin
          if (fh < 13'd3) begin
            h_last_d = 12'd2;
          end else if (fh > 13'd4096) begin
            h_last_d = 12'd4095;
          end else begin
            h_last_d = 12'(fh - 13'd1);
          end
        end
        default: begin
          w_last_d = w_last_q;
        end
      endcase
    end
  end

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (cfg_we_i) begin
      x_d = '0;
      y_d = '0;
    end else if (accept) begin
      if (x_q == w_last_q) begin
        x_d = '0;
        y_d = (y_q == h_last_q) ? 12'd0 : y_q + 12'd1;
      end else begin
        x_d = x_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q   <= CW'(W_RESET - 1);
      h_last_q   <= 12'd479;
      x_q        <= '0;
      y_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      w_last_q   <= w_last_d;
      h_last_q   <= h_last_d;
      x_q        <= x_d;
      y_q        <= y_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_gray_q      <= gray;
      s1_x_q         <= x_q;
      s1_produce_q   <= (y_q >= 12'd2) && (x_q >= CW'(2));
      s1_frame_end_q <= (y_q == h_last_q) && (x_q == w_last_q);
    end
  end

  // line store word: middle row in the high byte, upper row in the low byte
  les_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (RAM_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_x_q),
    .wdata_i ({s1_gray_q, rd_mid}),
    .re_i    (accept),
    .raddr_i (x_q),
    .rdata_o (ram_rdata)
  );

  assign rd_up  = ram_rdata[PIX_W-1:0];
  assign rd_mid = ram_rdata[RAM_W-1:PIX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q <= '0;
      win_up_q   <= '0;
      win_ctr_q  <= '0;
      win_down_q <= '0;
    end else if (cfg_we_i) begin
      win_left_q <= '0;
      win_up_q   <= '0;
      win_ctr_q  <= '0;
      win_down_q <= '0;
    end else if (s1_valid_q) begin
      win_left_q <= win_ctr_q;
      win_up_q   <= rd_up;
      win_ctr_q  <= rd_mid;
      win_down_q <= s1_gray_q;
    end
  end

  assign lap = $signed({1'b0, win_ctr_q, 2'b00})
             - $signed(11'(win_left_q)) - $signed(11'(win_up_q))
             - $signed(11'(rd_mid)) - $signed(11'(win_down_q));
  assign lap_abs = lap[10] ? 11'(-lap) : 11'(lap);

  assign res_item.edge_value = lap_abs[PIX_W-1:0];
  assign res_item.frame_end  = s1_frame_end_q;

  les_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q && s1_produce_q),
    .item_i  (res_item),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .item_o  (out_item),
    .count_o (fifo_count)
  );

  assign m_axis_tdata = out_item.edge_value;
  assign m_axis_tlast = out_item.frame_end;

endmodule

// ----- bench/laplacian_edge_stream_test.sv -----
// Self-checking stream testbench for the Laplacian edge detector with a built-in window predictor.
module laplacian_edge_stream_test;
  import les_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_COLS     = 2048;
  localparam int unsigned MAX_ROWS     = 4096;
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 580;

  typedef enum logic {
    PACE_BURST,
    PACE_JITTER
  } pace_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;

  logic [23:0] pixel_q [$];
  out_item_t   pending_edges [$];

  logic [11:0] width_reg = 12'd640;
  logic [12:0] height_reg = 13'd480;
  logic [7:0]  upper_row [MAX_COLS] = '{default: 8'h00};
  logic [7:0]  middle_row [MAX_COLS] = '{default: 8'h00};
  logic [7:0]  win [6] = '{default: 8'h00};
  int unsigned col = 0;
  int unsigned row = 0;

  pace_e       src_pace = PACE_JITTER;
  pace_e       sink_pace = PACE_JITTER;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned stuck_cycles = 0;

  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frame_ends_seen = 0;
  int unsigned cfg_writes = 0;

  laplacian_edge_stream #(
    .MAX_WIDTH(MAX_COLS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 3) return 3;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return height_reg;
  endfunction

  function automatic int unsigned pick_gap(pace_e p);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (p == PACE_BURST || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] rand_pixel();
    logic [23:0] px;
    int unsigned r;
    r = $urandom_range(0, 9);
    px = 24'($urandom());
    if (r < 2) begin
      for (int i = 0; i < 24; i += 8) px[i+:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else if (r < 4) begin
      px = {3{8'($urandom_range(100, 108))}};
    end
    return px;
  endfunction

  task automatic predict_edge(input logic [23:0] px);
    int unsigned w, h, x, y;
    logic [31:0] luma;
    logic [31:0] mag;
    logic [7:0]  up_now, mid_now;
    int          acc;
    out_item_t   want;
    w = eff_width();
    h = eff_height();
    x = col % MAX_COLS;
    y = row;
    luma = (32'(px[7:0]) * 32'(GRAY_K0) + 32'(px[15:8]) * 32'(GRAY_K1)
            + 32'(px[23:16]) * 32'(GRAY_K2) + 32'(GRAY_ROUND)) >> GRAY_SHIFT;
    up_now = upper_row[x];
    mid_now = middle_row[x];
    if (y >= 2 && x >= 2) begin
      acc = 4 * int'(win[4]) - int'(win[1]) - int'(win[3]) - int'(mid_now) - int'(win[5]);
      mag = (acc < 0) ? -acc : acc;
      want.edge_value = mag[7:0];
      want.frame_end = (y == h - 1 && x == w - 1);
      pending_edges.push_back(want);
    end
    upper_row[x] = mid_now;
    middle_row[x] = luma[7:0];
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up_now;
    win[4] = mid_now;
    win[5] = luma[7:0];
    if (x + 1 >= w) begin
      col = 0;
      row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col = x + 1;
    end
  endtask

  task automatic check_result(input logic [7:0] val, input logic last);
    out_item_t want;
    results_seen++;
    if (last) frame_ends_seen++;
    if (pending_edges.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("unexpected edge result %0d last %0b at %0t", val, last, $realtime);
    end else begin
      want = pending_edges.pop_front();
      if (want.edge_value !== val || want.frame_end !== last) begin
        error_count++;
        if (error_count <= 10)
          $display("edge mismatch at %0t: expected %0d last %0b, got %0d last %0b",
                   $realtime, want.edge_value, want.frame_end, val, last);
      end
    end
  endtask

  // Pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_edge(s_axis_tdata);
        pixels_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pixel_q.pop_front();
          src_gap <= pick_gap(src_pace);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Edge result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tlast);
      if (sink_stall != 0) begin
        sink_stall <= sink_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_stall <= pick_gap(sink_pace);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i ||
        !rst_ni) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("laplacian_edge_stream_test: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_cfg(input cfg_reg_e idx, input logic [12:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_FRAME_WIDTH) width_reg = val[11:0];
    else height_reg = val;
    col = 0;
    row = 0;
    win = '{default: 8'h00};
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || s_axis_tvalid || pending_edges.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_pace(input pace_e src, input pace_e sink);
    @(negedge clk_i);
    src_pace = src;
    sink_pace = sink;
  endtask

  task automatic queue_pixels(input int unsigned n);
    @(negedge clk_i);
    repeat (n) pixel_q.push_back(rand_pixel());
  endtask

  task automatic queue_frame3(input logic [23:0] centre, input logic [23:0] rest);
    @(negedge clk_i);
    for (int i = 0; i < 9; i++) pixel_q.push_back(i == 4 ? centre : rest);
  endtask

  initial begin : stimulus
    int unsigned random_items;
    int unsigned n, r;
    random_items = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: 640 wide, part of the first row, so nothing comes out
    queue_pixels(60);
    wait_idle();

    write_cfg(REG_FRAME_WIDTH, 13'd3);
    write_cfg(REG_FRAME_HEIGHT, 13'd3);
    queue_frame3(24'hFFFFFF, 24'h000000);
    queue_frame3(24'h000000, 24'hFFFFFF);
    @(negedge clk_i);
    pixel_q.push_back(24'h0000FF);
    pixel_q.push_back(24'h00FF00);
    pixel_q.push_back(24'hFF0000);
    pixel_q.push_back(24'hFFFFFF);
    pixel_q.push_back(24'h000000);
    pixel_q.push_back(24'h7F807F);
    pixel_q.push_back(24'h807F80);
    wait_idle();

    // Saturated and masked geometry, restarting mid-frame
    write_cfg(REG_FRAME_WIDTH, 13'd0);
    write_cfg(REG_FRAME_HEIGHT, 13'd0);
    queue_pixels(21);
    wait_idle();
    write_cfg(REG_FRAME_WIDTH, 13'h1004);
    write_cfg(REG_FRAME_HEIGHT, 13'd1);
    queue_pixels(14);
    wait_idle();
    write_cfg(REG_FRAME_WIDTH, 13'd2);
    write_cfg(REG_FRAME_HEIGHT, 13'd2);
    queue_pixels(10);
    wait_idle();

    set_pace(PACE_BURST, PACE_JITTER);
    write_cfg(REG_FRAME_WIDTH, 13'h1FFF);
    write_cfg(REG_FRAME_HEIGHT, 13'd3);
    queue_pixels(100);
    wait_idle();

    set_pace(PACE_BURST, PACE_BURST);
    write_cfg(REG_FRAME_WIDTH, 13'd3);
    write_cfg(REG_FRAME_HEIGHT, 13'h1FFF);
    queue_pixels(30);
    wait_idle();

    while (random_items < RANDOM_ITEMS) begin
      set_pace(pace_e'($urandom_range(0, 1)), pace_e'($urandom_range(0, 1)));
      r = (random_items == 0) ? 0 : $urandom_range(0, 99);
      if (r < 60) begin
        write_cfg(REG_FRAME_WIDTH, 13'($urandom_range(3, 24)));
        write_cfg(REG_FRAME_HEIGHT, 13'($urandom_range(3, 8)));
      end else if (r < 75) begin
        write_cfg(REG_FRAME_WIDTH, 13'($urandom_range(0, 24)));
      end else if (r < 90) begin
        write_cfg(REG_FRAME_HEIGHT, 13'($urandom_range(0, 8)));
      end
      n = $urandom_range(1, 2 * eff_width() * eff_height() + 4);
      if (n > 100) n = 100;
      if ($urandom_range(0, 4) == 0) begin
        // hold the sender until every pending edge has drained
        queue_pixels(n / 2);
        wait_idle();
        queue_pixels(n - n / 2);
      end else begin
        queue_pixels(n);
      end
      random_items += n;
      wait_idle();
    end

    wait_idle();
    $display("covered %0d pixels across %0d register writes; %0d edge results, %0d frame ends",
             pixels_sent, cfg_writes, results_seen, frame_ends_seen);
    $display("geometry ranged from clamped 3x3 to saturated width and height, with stalls");
    if (error_count == 0) begin
      $display("laplacian_edge_stream_test: done, clean");
    end else begin
      $display("laplacian_edge_stream_test: done, errors");
    end
    $finish;
  end

endmodule
